>>> rtl/bead_width_splitter_macros.svh
// assertion macros for the bead width splitter
// expects clk and arst_n in the including module
`ifndef BEAD_WIDTH_SPLITTER_MACROS_SVH
`define BEAD_WIDTH_SPLITTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define BWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bws_pkg.sv
// shared types and constants for the bead width splitter
// no dependencies
`default_nettype none

package bws_pkg;

	localparam int TW = 20;
	localparam int CNTW = 6;
	localparam int IDXW = 5;
	localparam int DIV_CNT_W = $clog2(TW + 1);

	typedef logic [TW-1:0] width_t;

	localparam logic CFG_OUTER_WIDTH = 1'b0;
	localparam logic CFG_MIN_WIDTH = 1'b1;

	localparam width_t OUTER_WIDTH_RST = width_t'(400);
	localparam width_t MIN_WIDTH_RST = width_t'(300);

endpackage

`default_nettype wire

>>> rtl/bead_width_splitter.sv
// path: an input passes S_MUL, S_CMP, S_DIV (the 20-step divider) and S_EMIT to the output register
// the minimum-width split skips S_DIV; zero beads go straight from S_IDLE to S_EMIT
// throughput: one bead beat per cycle while sweeping unless out_ready stalls, one input at a time
// reset: registers return to 400 and 300, control and output valid clear
// depends on bws_pkg, bws_div and bead_width_splitter_macros.svh
`default_nettype none

`include "bead_width_splitter_macros.svh"

module bead_width_splitter #(
	parameter int MAX_BEADS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire bws_pkg::width_t cfg_data,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire bws_pkg::width_t thickness,
	input  wire logic [5:0]      num_beads,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [4:0]           bead_index,
	output bws_pkg::width_t      bead_width,
	output bws_pkg::width_t      bead_location,
	output bws_pkg::width_t      leftover,
	output logic                 last
);

	import bws_pkg::*;

	localparam int NW = $clog2(MAX_BEADS + 1);
	localparam int IW = $clog2(MAX_BEADS);
	localparam int CMPW = NW + CNTW;
	localparam int PW = NW + TW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_CMP,
		S_DIV,
		S_EMIT
	} state_t;

	state_t          state_q;
	width_t          ow_q;
	width_t          mw_q;
	width_t          t_q;
	logic [NW-1:0]   n_q;
	logic            zero_q;
	logic            mode_outer_q;
	logic [PW-1:0]   p_q;
	width_t          w0_q;
	width_t          win_q;
	width_t          acc_q;
	width_t          tacc_q;
	logic [IW-1:0]   idx_q;

	logic            out_valid_q;
	logic [IDXW-1:0] idx_out_q;
	width_t          width_out_q;
	width_t          loc_out_q;
	width_t          left_out_q;
	logic            last_out_q;

	logic [NW-1:0]   n_clamped;
	logic [NW-1:0]   nm2;
	logic [PW-1:0]   prod;
	logic [PW:0]     sum_a;
	logic [PW:0]     sum_b;
	logic [PW:0]     t_wide;
	logic            take_a;
	logic            take_b;
	logic            div_start;
	width_t          div_dividend;
	logic [NW-1:0]   div_divisor;
	logic            div_busy;
	logic            div_done;
	width_t          div_quot;

	logic [NW-1:0]   idx_ext;
	logic [NW-1:0]   n_last;
	logic            is_outer;
	logic            is_middle;
	logic            is_first;
	logic            is_last;
	width_t          w_cur;
	width_t          w_half;
	width_t          w_ceil;
	logic [IW+IDXW-1:0] idx_wide;
	logic            slot_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q <= OUTER_WIDTH_RST;
			mw_q <= MIN_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OUTER_WIDTH: ow_q <= cfg_data;
				CFG_MIN_WIDTH: mw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_clamped = (CMPW'(num_beads) > CMPW'(MAX_BEADS)) ? NW'(MAX_BEADS)
		: NW'(num_beads);

	// split decision
	assign nm2 = n_q - NW'(2);
	assign prod = PW'(nm2) * PW'(mw_q);
	assign t_wide = (PW + 1)'(t_q);
	assign sum_a = (PW + 1)'(p_q) + (PW + 1)'({ow_q, 1'b0});
	assign sum_b = (PW + 1)'(p_q) + (PW + 1)'({mw_q, 1'b0});
	assign take_a = (n_q > NW'(2)) && (t_wide >= sum_a);
	assign take_b = !take_a && (n_q > NW'(2)) && (t_wide >= sum_b);

	assign div_start = (state_q == S_CMP) && !take_b;
	assign div_dividend = take_a ? (t_q - {ow_q[TW-2:0], 1'b0}) : t_q;
	assign div_divisor = take_a ? nm2 : n_q;

	bws_div #(
		.DW(NW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quot)
	);

	// bead sweep
	assign idx_ext = NW'(idx_q);
	assign n_last = n_q - NW'(1);
	assign is_outer = (idx_q == '0) || (idx_ext == n_last);
	assign is_middle = n_q[0] && (idx_ext == (n_q >> 1));
	assign is_first = idx_ext <= (n_last >> 1);
	assign is_last = idx_ext == n_last;
	assign w_cur = is_outer ? w0_q : win_q;
	assign w_half = w_cur >> 1;
	assign w_ceil = w_cur - w_half;
	assign idx_wide = (IW + IDXW)'(idx_q);
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q <= '0;
			n_q <= '0;
			zero_q <= 1'b0;
			mode_outer_q <= 1'b0;
			p_q <= '0;
			w0_q <= '0;
			win_q <= '0;
			acc_q <= '0;
			tacc_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			idx_out_q <= '0;
			width_out_q <= '0;
			loc_out_q <= '0;
			left_out_q <= '0;
			last_out_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						t_q <= thickness;
						n_q <= n_clamped;
						zero_q <= (num_beads == '0);
						idx_q <= '0;
						state_q <= (num_beads == '0) ? S_EMIT : S_MUL;
					end
				end
				S_MUL: begin
					p_q <= prod;
					state_q <= S_CMP;
				end
				S_CMP: begin
					acc_q <= '0;
					tacc_q <= t_q;
					if (take_a) begin
						mode_outer_q <= 1'b1;
						state_q <= S_DIV;
					end else if (take_b) begin
						w0_q <= (t_q - p_q[TW-1:0]) >> 1;
						win_q <= mw_q;
						state_q <= S_EMIT;
					end else begin
						mode_outer_q <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						w0_q <= mode_outer_q ? ow_q : div_quot;
						win_q <= div_quot;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (zero_q) begin
							idx_out_q <= '0;
							width_out_q <= '0;
							loc_out_q <= '0;
							left_out_q <= t_q;
							last_out_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							idx_out_q <= idx_wide[IDXW-1:0];
							width_out_q <= w_cur;
							left_out_q <= '0;
							last_out_q <= is_last;
							if (is_middle) begin
								loc_out_q <= t_q >> 1;
							end else if (is_first) begin
								loc_out_q <= acc_q + w_half;
								acc_q <= acc_q + w_cur;
								tacc_q <= tacc_q - w_cur;
							end else begin
								loc_out_q <= tacc_q + w_ceil;
								tacc_q <= tacc_q + w_cur;
							end
							idx_q <= idx_q + IW'(1);
							if (is_last) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign bead_index = idx_out_q;
	assign bead_width = width_out_q;
	assign bead_location = loc_out_q;
	assign leftover = left_out_q;
	assign last = last_out_q;

	`BWS_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_busy, "divider busy while idle")
	`BWS_ASSERT_NOW(a_sweep_holds_input, out_valid && !last, !in_ready,
		"input taken before the last bead")
	`BWS_ASSERT_NOW(a_leftover_only_empty, out_valid && (leftover != '0),
		last && (bead_width == '0), "leftover on a bead result")
	`BWS_ASSERT_NOW(a_index_in_range, (state_q == S_EMIT) && !zero_q, idx_ext < n_q,
		"bead index past count")

endmodule

`default_nettype wire

>>> rtl/bws_div.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on bws_pkg
`default_nettype none

module bws_div #(
	parameter int DW = 7
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire bws_pkg::width_t dividend,
	input  wire logic [DW-1:0]  divisor,
	output logic                busy,
	output logic                done,
	output bws_pkg::width_t     quotient
);

	import bws_pkg::*;

	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        dvs_q;
	width_t               quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DW:0]          rem_sh;
	logic [DW:0]          rem_sub;
	logic                 fits;

	assign rem_sh = {rem_q, quo_q[TW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign fits = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(TW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_sub[DW-1:0];
				quo_q <= {quo_q[TW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				quo_q <= {quo_q[TW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> dv/bead_width_splitter_tb.sv
// self-checking testbench for bead_width_splitter: random wall beats in, bead beats checked
// against an in-bench bead split predictor, under several register settings and idle mixes
// depends on bws_pkg and the bead_width_splitter rtl
module bead_width_splitter_tb;
	import bws_pkg::*;

	localparam int BEAD_LIMIT = 32;
	localparam int CYCLE_LIMIT = 500000;
	localparam longint unsigned W20_MAX = 64'hFFFFF;

	typedef struct {
		width_t     thick;
		logic [5:0] count;
	} wall_t;

	typedef struct {
		logic [4:0] index;
		width_t     width;
		width_t     location;
		width_t     left;
		logic       last;
	} bead_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_OUTER_WIDTH;
	width_t     cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	width_t     thickness = '0;
	logic [5:0] num_beads = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [4:0] bead_index;
	width_t     bead_width;
	width_t     bead_location;
	width_t     leftover;
	logic       last;

	wall_t      pending_walls[$];
	bead_beat_t beads_due[$];
	bead_beat_t due_beat;

	longint unsigned outer_target = OUTER_WIDTH_RST;
	longint unsigned inner_floor = MIN_WIDTH_RST;
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	bead_width_splitter #(.MAX_BEADS(BEAD_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.thickness(thickness),
		.num_beads(num_beads),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bead_index(bead_index),
		.bead_width(bead_width),
		.bead_location(bead_location),
		.leftover(leftover),
		.last(last)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		mismatches++;
	endtask

	// split one wall into beads and queue the beats it should produce
	function automatic void predict_beads(input width_t t_in, input logic [5:0] cnt);
		longint unsigned t, n, half, acc;
		longint unsigned wid[BEAD_LIMIT];
		longint unsigned loc[BEAD_LIMIT];
		bead_beat_t b;
		t = t_in;
		n = cnt;
		if (n == 0) begin
			b = '{index: '0, width: '0, location: '0, left: t_in, last: 1'b1};
			beads_due.push_back(b);
			return;
		end
		if (n > BEAD_LIMIT)
			n = BEAD_LIMIT;
		half = (n + 1) / 2;
		if (n == 1) begin
			wid[0] = t;
		end else if (n > 2 && t >= 2 * outer_target + (n - 2) * inner_floor) begin
			wid[0] = outer_target;
			for (int i = 1; i < half; i++)
				wid[i] = (t - 2 * outer_target) / (n - 2);
		end else if (t >= n * inner_floor) begin
			wid[0] = (t - inner_floor * (n - 2)) / 2;
			for (int i = 1; i < half; i++)
				wid[i] = inner_floor;
		end else begin
			for (int i = 0; i < half; i++)
				wid[i] = t / n;
		end
		acc = 0;
		for (int i = 0; i < half; i++) begin
			loc[i] = wid[i] / 2 + acc;
			acc += wid[i];
		end
		if (n[0])
			loc[n / 2] = t / 2;
		for (int i = int'(half); i < n; i++) begin
			wid[i] = wid[n - 1 - i];
			loc[i] = t - loc[n - 1 - i];
		end
		for (int i = 0; i < n; i++) begin
			b.index = 5'(i);
			b.width = width_t'(wid[i]);
			b.location = width_t'(loc[i]);
			b.left = '0;
			b.last = (i + 1 == n);
			beads_due.push_back(b);
		end
	endfunction

	// random wall, thickness often aimed at the split thresholds
	function automatic wall_t random_wall();
		wall_t w;
		longint unsigned n, ns, bound;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			n = 0;
		else if (pick < 12)
			n = $urandom_range(63, 33);
		else if (pick < 25)
			n = $urandom_range(2, 1);
		else
			n = $urandom_range(32, 3);
		ns = (n > BEAD_LIMIT) ? BEAD_LIMIT : n;
		case ($urandom_range(3))
			0: bound = (ns > 2) ? 2 * outer_target + (ns - 2) * inner_floor
				: ns * inner_floor;
			1: bound = ns * inner_floor;
			default: bound = W20_MAX + 100;
		endcase
		if (bound + 4 > W20_MAX)
			w.thick = ($urandom_range(1)) ? width_t'($urandom) : width_t'($urandom_range(4095));
		else if (bound < 4)
			w.thick = width_t'($urandom_range(8));
		else
			w.thick = width_t'(bound + $urandom_range(8) - 4);
		w.count = 6'(n);
		return w;
	endfunction

	task automatic write_reg(input logic idx, input longint unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= width_t'(value);
		if (idx == CFG_OUTER_WIDTH)
			outer_target = value;
		else
			inner_floor = value;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_walls.size() != 0 || in_valid || beads_due.size() != 0);
	endtask

	task automatic push_wall(input longint unsigned t, input longint unsigned n);
		wall_t w;
		w.thick = width_t'(t);
		w.count = 6'(n);
		pending_walls.push_back(w);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_beads(thickness, num_beads);
			if (!in_valid || in_ready) begin
				if (pending_walls.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					wall_t w;
					w = pending_walls.pop_front();
					in_valid <= 1'b1;
					thickness <= w.thick;
					num_beads <= w.count;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (beads_due.size() == 0) begin
					flag_mismatch($sformatf("bead beat index %0d with nothing expected",
						bead_index));
				end else begin
					due_beat = beads_due.pop_front();
					if (bead_index !== due_beat.index)
						flag_mismatch($sformatf("bead_index %0d, expected %0d",
							bead_index, due_beat.index));
					if (bead_width !== due_beat.width)
						flag_mismatch($sformatf("bead %0d width %0d, expected %0d",
							due_beat.index, bead_width, due_beat.width));
					if (bead_location !== due_beat.location)
						flag_mismatch($sformatf("bead %0d location %0d, expected %0d",
							due_beat.index, bead_location, due_beat.location));
					if (leftover !== due_beat.left)
						flag_mismatch($sformatf("bead %0d leftover %0d, expected %0d",
							due_beat.index, leftover, due_beat.left));
					if (last !== due_beat.last)
						flag_mismatch($sformatf("bead %0d last %b, expected %b",
							due_beat.index, last, due_beat.last));
				end
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		longint unsigned settings[6][2];
		settings = '{'{1, 1}, '{W20_MAX, W20_MAX}, '{W20_MAX, 1}, '{1, W20_MAX},
			'{0, 0}, '{0, 0}};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed walls at reset register values
		push_wall(0, 0);
		push_wall(W20_MAX, 0);
		push_wall(W20_MAX, 1);
		push_wall(0, 1);
		push_wall(600, 2);
		push_wall(599, 2);
		push_wall(1100, 3);
		push_wall(1099, 3);
		push_wall(899, 3);
		push_wall(12345, 5);
		push_wall(12346, 6);
		push_wall(2900, 8);
		push_wall(2399, 8);
		push_wall(W20_MAX, 32);
		push_wall(W20_MAX, 63);
		push_wall(5000, 33);
		push_wall(0, 32);
		push_wall(1, 32);
		push_wall(20'hAAAAA, 17);
		push_wall(20'h55555, 42);
		push_wall(31, 31);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			if (p >= 4) begin
				settings[p][0] = $urandom_range(p == 4 ? 2000 : 40000, 1);
				settings[p][1] = $urandom_range(p == 4 ? 2000 : 40000, 1);
			end
			write_reg(CFG_OUTER_WIDTH, settings[p][0]);
			write_reg(CFG_MIN_WIDTH, settings[p][1]);
			@(posedge clk);
			cfg_we <= 1'b0;
			for (int m = 0; m < 4; m++) begin
				case (m)
					0: begin send_gap_pct = 0; stall_pct = 0; end
					1: begin send_gap_pct = 62; stall_pct = 0; end
					2: begin send_gap_pct = 0; stall_pct = 62; end
					default: begin send_gap_pct = 10; stall_pct = 10; end
				endcase
				repeat (8)
					pending_walls.push_back(random_wall());
				wait_idle();
			end
		end

		send_gap_pct = 0;
		stall_pct = 0;
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
